FILE: rtl/mkit_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-key instance table: sizes, row type, command and
// status codes, and the control bundle that drives the row cells. No dependencies.
package mkit_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [CAPACITY-1:0] vec_t;

    typedef enum logic [2:0] {
        CMD_INSERT     = 3'd0,
        CMD_LOOKUP_KEY = 3'd1,
        CMD_LOOKUP_INS = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_RENUMBER   = 3'd4
    } cmd_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic [15:0] inst;
        logic [15:0] spawn;
        logic [15:0] blk;
        logic [7:0]  mesh;
    } row_t;

    // Broadcast to every cell during the apply cycle
    typedef struct packed {
        logic        remove_en;
        logic        renumber_en;
        logic [15:0] thr_block;
        logic [7:0]  thr_mesh;
    } cell_ctl_t;

endpackage

FILE: rtl/mkit_cell.sv
`timescale 1ns / 1ps
// One row cell of the instance table: holds a row and its registered match flag.
// Depends on mkit_pkg.
module mkit_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capture,
    input  mkit_pkg::cmd_t     command,
    input  logic [15:0]        instance_number,
    input  logic [15:0]        spawn_instance,
    input  logic [15:0]        block_number,
    input  logic [7:0]         mesh_number,
    input  logic               row_valid,
    input  mkit_pkg::cell_ctl_t ctl,
    input  logic               insert_sel,
    input  logic               shift_sel,
    input  mkit_pkg::row_t     new_row,
    input  mkit_pkg::row_t     next_row,
    output mkit_pkg::row_t     row,
    output logic               match
);

    mkit_pkg::row_t row_reg;
    mkit_pkg::row_t row_next;
    logic           match_reg;
    logic           match_next;
    logic           key_eq;
    logic           inst_eq;

    assign key_eq  = (row_reg.spawn == spawn_instance) && (row_reg.blk == block_number)
                     && (row_reg.mesh == mesh_number);
    assign inst_eq = (row_reg.inst == instance_number);

    always_comb
    begin
        match_next = match_reg;
        if (capture)
        begin
            if (command == mkit_pkg::CMD_LOOKUP_KEY)
                match_next = row_valid && key_eq;
            else
                match_next = row_valid && inst_eq;
        end
    end

    always_comb
    begin
        row_next = row_reg;
        if (insert_sel)
        begin
            row_next = new_row;
        end
        else if (shift_sel)
        begin
            // take the upper neighbor, instance moves down by one
            row_next      = next_row;
            row_next.inst = next_row.inst - 16'd1;
        end
        else if (ctl.renumber_en && (row_reg.mesh == ctl.thr_mesh)
                 && (row_reg.blk > ctl.thr_block))
        begin
            row_next.blk = row_reg.blk - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign row   = row_reg;
    assign match = match_reg;

endmodule

FILE: rtl/mkit_resolve.sv
`timescale 1ns / 1ps
// First-match resolver: picks the lowest matching cell, selects its row and
// builds the mask of cells at and above it. Depends on mkit_pkg.
module mkit_resolve (
    input  mkit_pkg::vec_t match,
    input  mkit_pkg::row_t rows [mkit_pkg::CAPACITY],
    output logic           found,
    output mkit_pkg::vec_t ge_mask,
    output mkit_pkg::row_t sel_row
);

    mkit_pkg::vec_t dec;
    mkit_pkg::vec_t first;

    // one subtract yields both the lowest set bit and the bits below it
    assign dec     = match - mkit_pkg::vec_t'(1);
    assign first   = match & ~dec;
    assign ge_mask = ~(dec & ~match);
    assign found   = |match;

    always_comb
    begin
        sel_row = '0;
        for (int i = 0; i < mkit_pkg::CAPACITY; i++)
        begin
            if (first[i])
                sel_row = sel_row | rows[i];
        end
    end

endmodule

FILE: rtl/multi_key_instance_table_unit.sv
`timescale 1ns / 1ps
// Multi-key instance table, top level: command channel, row cell chain,
// resolver and result register. Depends on mkit_pkg, mkit_cell, mkit_resolve.
//
// Usage:
//   A request (command plus key fields) enters on in_valid/in_ready and
//   yields exactly one result on out_valid/out_ready: status and the found
//   fields, which are zero unless a lookup hits.
//   Each row sits in a cell of a chain. On the accept edge every cell
//   compares its row against the request and registers a match flag; on
//   the next edge the lowest match is resolved, the cells update (append,
//   shift down on remove, block renumber) and the result is registered.
//   out_valid rises with the resolve/update edge, when the result is registered.
//   A new request is not taken during the resolve/update cycle of the cell
//   chain; in_ready is low in the apply state.
//   A request is taken while a result waits only if that result is drained
//   in the same cycle; a stalled receiver holds the result and blocks the
//   next request.
//   Reset empties the table (row count zero) and drops any pending result;
//   no clearing pass is needed.
module multi_key_instance_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [15:0] instance_number,
    input  logic [15:0] spawn_instance,
    input  logic [15:0] block_number,
    input  logic [7:0]  mesh_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] found_instance,
    output logic [15:0] found_block,
    output logic [7:0]  found_mesh
);

    mkit_pkg::state_t state_reg;
    mkit_pkg::state_t state_next;

    mkit_pkg::cmd_t   cmd_in;
    mkit_pkg::cmd_t   cmd_reg;
    mkit_pkg::row_t   op_row_reg;
    logic [mkit_pkg::CNT_W-1:0] cnt_reg;
    logic [mkit_pkg::CNT_W-1:0] cnt_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [15:0] f_inst_reg;
    logic [15:0] f_inst_next;
    logic [15:0] f_blk_reg;
    logic [15:0] f_blk_next;
    logic [7:0]  f_mesh_reg;
    logic [7:0]  f_mesh_next;

    logic                accept;
    logic                apply;
    logic                full;
    logic                found;
    mkit_pkg::cell_ctl_t ctl;
    mkit_pkg::vec_t      match;
    mkit_pkg::vec_t      ge_mask;
    mkit_pkg::vec_t      row_valid;
    mkit_pkg::vec_t      insert_sel;
    mkit_pkg::vec_t      shift_sel;
    mkit_pkg::row_t      rows [mkit_pkg::CAPACITY];
    mkit_pkg::row_t      next_rows [mkit_pkg::CAPACITY];
    mkit_pkg::row_t      sel_row;

    assign cmd_in = mkit_pkg::cmd_t'(command);
    assign full   = (cnt_reg == mkit_pkg::CNT_W'(mkit_pkg::CAPACITY));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mkit_pkg::S_IDLE:
            begin
                if (in_valid && (!out_valid_reg || out_ready))
                    state_next = mkit_pkg::S_APPLY;
            end
            mkit_pkg::S_APPLY:
            begin
                state_next = mkit_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mkit_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        apply    = 1'b0;
        case (state_reg)
            mkit_pkg::S_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
            end
            mkit_pkg::S_APPLY:
            begin
                apply = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        ctl.remove_en   = apply && (cmd_reg == mkit_pkg::CMD_REMOVE) && found;
        ctl.renumber_en = apply && (cmd_reg == mkit_pkg::CMD_RENUMBER);
        ctl.thr_block   = op_row_reg.blk;
        ctl.thr_mesh    = op_row_reg.mesh;
    end

    mkit_resolve u_resolve (
        .match   (match),
        .rows    (rows),
        .found   (found),
        .ge_mask (ge_mask),
        .sel_row (sel_row)
    );

    genvar gi;
    generate
        for (gi = 0; gi < mkit_pkg::CAPACITY; gi++)
        begin : g_cell
            assign row_valid[gi]  = (mkit_pkg::CNT_W'(gi) < cnt_reg);
            assign insert_sel[gi] = apply && (cmd_reg == mkit_pkg::CMD_INSERT) && !full
                                    && (cnt_reg == mkit_pkg::CNT_W'(gi));
            assign shift_sel[gi]  = ctl.remove_en && ge_mask[gi];

            if (gi == mkit_pkg::CAPACITY - 1)
            begin : g_last
                assign next_rows[gi] = '0;
            end
            else
            begin : g_mid
                assign next_rows[gi] = rows[gi+1];
            end

            mkit_cell u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .capture         (accept),
                .command         (cmd_in),
                .instance_number (instance_number),
                .spawn_instance  (spawn_instance),
                .block_number    (block_number),
                .mesh_number     (mesh_number),
                .row_valid       (row_valid[gi]),
                .ctl             (ctl),
                .insert_sel      (insert_sel[gi]),
                .shift_sel       (shift_sel[gi]),
                .new_row         (op_row_reg),
                .next_row        (next_rows[gi]),
                .row             (rows[gi]),
                .match           (match[gi])
            );
        end
    endgenerate

    // result and row count
    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        f_inst_next    = f_inst_reg;
        f_blk_next     = f_blk_reg;
        f_mesh_next    = f_mesh_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (apply)
        begin
            out_valid_next = 1'b1;
            status_next    = mkit_pkg::STAT_MISS;
            f_inst_next    = '0;
            f_blk_next     = '0;
            f_mesh_next    = '0;
            case (cmd_reg)
                mkit_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = mkit_pkg::STAT_FULL;
                    end
                    else
                    begin
                        status_next = mkit_pkg::STAT_OK;
                        cnt_next    = cnt_reg + mkit_pkg::CNT_W'(1);
                    end
                end
                mkit_pkg::CMD_LOOKUP_KEY:
                begin
                    if (found)
                    begin
                        status_next = mkit_pkg::STAT_OK;
                        f_inst_next = sel_row.inst;
                    end
                end
                mkit_pkg::CMD_LOOKUP_INS:
                begin
                    if (found)
                    begin
                        status_next = mkit_pkg::STAT_OK;
                        f_blk_next  = sel_row.blk;
                        f_mesh_next = sel_row.mesh;
                    end
                end
                mkit_pkg::CMD_REMOVE:
                begin
                    if (found)
                    begin
                        status_next = mkit_pkg::STAT_OK;
                        cnt_next    = cnt_reg - mkit_pkg::CNT_W'(1);
                    end
                end
                mkit_pkg::CMD_RENUMBER:
                begin
                    status_next = mkit_pkg::STAT_OK;
                end
                default:
                begin
                    status_next = mkit_pkg::STAT_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mkit_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg          <= cmd_in;
            op_row_reg.inst  <= instance_number;
            op_row_reg.spawn <= spawn_instance;
            op_row_reg.blk   <= block_number;
            op_row_reg.mesh  <= mesh_number;
        end
        status_reg <= status_next;
        f_inst_reg <= f_inst_next;
        f_blk_reg  <= f_blk_next;
        f_mesh_reg <= f_mesh_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_instance = f_inst_reg;
    assign found_block    = f_blk_reg;
    assign found_mesh     = f_mesh_reg;

endmodule

FILE: rtl/mkit_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the instance table and its bind to the top level.
// Depends on mkit_pkg and multi_key_instance_table_unit.
module mkit_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] found_instance,
    input logic [15:0] found_block,
    input logic [7:0]  found_mesh
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted back to back");

    // result becomes valid after each accepted request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("result missing after request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
                                       && $stable(found_instance)))
        else $error("stalled result changed");

    // a non-ok result carries zero data and a defined status code
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != mkit_pkg::STAT_OK))
            |-> ((found_instance == 16'd0) && (found_block == 16'd0)
                 && (found_mesh == 8'd0) && (status != 2'd3)))
        else $error("non-ok result with data");

endmodule

bind multi_key_instance_table_unit mkit_checker u_mkit_checker (.*);

FILE: dv/multi_key_instance_table_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for multi_key_instance_table_unit: a directed walk and random command mixes,
// each result scored against its typed value or a row-table predictor. Depends on mkit_pkg and the RTL.
module multi_key_instance_table_unit_tb;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 80;
    localparam int MAX_GAP     = 11;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] inst;
        logic [15:0] spawn;
        logic [15:0] blk;
        logic [7:0]  mesh;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] f_inst;
        logic [15:0] f_blk;
        logic [7:0]  f_mesh;
    } result_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        result_t  res;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [15:0] instance_number;
    logic [15:0] spawn_instance;
    logic [15:0] block_number;
    logic [7:0]  mesh_number;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] found_instance;
    logic [15:0] found_block;
    logic [7:0]  found_mesh;

    // Predicted table contents
    int          row_total;
    logic [15:0] rows_inst  [mkit_pkg::CAPACITY];
    logic [15:0] rows_spawn [mkit_pkg::CAPACITY];
    logic [15:0] rows_blk   [mkit_pkg::CAPACITY];
    logic [7:0]  rows_mesh  [mkit_pkg::CAPACITY];

    result_t       awaited_results [$];
    result_t       oldest_result;
    directed_row_t directed_rows [$];
    int            error_count;
    int            cycle_count;
    bit            sender_quiet;
    bit            receiver_quiet;
    bit            long_hold_pending;

    multi_key_instance_table_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .instance_number (instance_number),
        .spawn_instance  (spawn_instance),
        .block_number    (block_number),
        .mesh_number     (mesh_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found_instance  (found_instance),
        .found_block     (found_block),
        .found_mesh      (found_mesh)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Update the predicted rows with one request and return its result
    function automatic result_t apply_to_rows(request_t r);
        result_t res;
        int      pos;
        res        = '0;
        res.status = mkit_pkg::STAT_MISS;
        pos        = -1;
        case (r.cmd)
            mkit_pkg::CMD_INSERT:
                if (row_total >= mkit_pkg::CAPACITY)
                    res.status = mkit_pkg::STAT_FULL;
                else
                begin
                    rows_inst[row_total]  = r.inst;
                    rows_spawn[row_total] = r.spawn;
                    rows_blk[row_total]   = r.blk;
                    rows_mesh[row_total]  = r.mesh;
                    row_total++;
                    res.status = mkit_pkg::STAT_OK;
                end
            mkit_pkg::CMD_LOOKUP_KEY:
            begin
                for (int i = 0; i < row_total; i++)
                    if (pos < 0 && rows_spawn[i] == r.spawn && rows_blk[i] == r.blk &&
                        rows_mesh[i] == r.mesh)
                        pos = i;
                if (pos >= 0)
                begin
                    res.status = mkit_pkg::STAT_OK;
                    res.f_inst = rows_inst[pos];
                end
            end
            mkit_pkg::CMD_LOOKUP_INS, mkit_pkg::CMD_REMOVE:
            begin
                for (int i = 0; i < row_total; i++)
                    if (pos < 0 && rows_inst[i] == r.inst)
                        pos = i;
                if (pos >= 0)
                begin
                    res.status = mkit_pkg::STAT_OK;
                    if (r.cmd == mkit_pkg::CMD_LOOKUP_INS)
                    begin
                        res.f_blk  = rows_blk[pos];
                        res.f_mesh = rows_mesh[pos];
                    end
                    else
                    begin
                        // close the gap; later rows lose one from their instance
                        for (int i = pos; i + 1 < row_total; i++)
                        begin
                            rows_inst[i]  = rows_inst[i + 1] - 16'd1;
                            rows_spawn[i] = rows_spawn[i + 1];
                            rows_blk[i]   = rows_blk[i + 1];
                            rows_mesh[i]  = rows_mesh[i + 1];
                        end
                        row_total--;
                    end
                end
            end
            mkit_pkg::CMD_RENUMBER:
            begin
                for (int i = 0; i < row_total; i++)
                    if (rows_mesh[i] == r.mesh && rows_blk[i] > r.blk)
                        rows_blk[i] = rows_blk[i] - 16'd1;
                res.status = mkit_pkg::STAT_OK;
            end
            default:
                ;
        endcase
        return res;
    endfunction

    // Mostly narrow keys or keys copied from live rows, so hits and wraps are common
    function automatic request_t random_request(int ins_pct, int rem_pct);
        request_t r;
        int       pick;
        int       row;
        r.inst  = 16'($urandom);
        r.spawn = 16'($urandom);
        r.blk   = 16'($urandom);
        r.mesh  = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            r.inst  = 16'($urandom_range(0, 15));
            r.spawn = 16'($urandom_range(0, 7));
            r.blk   = 16'($urandom_range(0, 31));
            r.mesh  = 8'($urandom_range(0, 3));
        end
        pick = $urandom_range(0, 99);
        if (pick < ins_pct)
            r.cmd = mkit_pkg::CMD_INSERT;
        else if (pick < ins_pct + rem_pct)
            r.cmd = mkit_pkg::CMD_REMOVE;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r.cmd = mkit_pkg::CMD_LOOKUP_KEY;
            else if (pick < 70)
                r.cmd = mkit_pkg::CMD_LOOKUP_INS;
            else if (pick < 93)
                r.cmd = mkit_pkg::CMD_RENUMBER;
            else
                r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        if (row_total > 0 && $urandom_range(0, 9) < 7)
        begin
            row     = $urandom_range(0, row_total - 1);
            r.inst  = rows_inst[row];
            r.spawn = rows_spawn[row];
            r.blk   = rows_blk[row];
            r.mesh  = rows_mesh[row];
            if ($urandom_range(0, 4) == 0)
                case ($urandom_range(0, 3))
                    0: r.inst  = r.inst ^ (16'd1 << $urandom_range(0, 15));
                    1: r.spawn = r.spawn ^ (16'd1 << $urandom_range(0, 15));
                    2: r.blk   = r.blk - 16'($urandom_range(1, 3));
                    default: r.mesh = r.mesh ^ (8'd1 << $urandom_range(0, 7));
                endcase
        end
        return r;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [15:0] inst,
                           input logic [15:0] spawn, input logic [15:0] blk,
                           input logic [7:0] mesh, input logic typed,
                           input logic [1:0] st, input logic [15:0] fi,
                           input logic [15:0] fb, input logic [7:0] fm);
        directed_row_t d;
        d.req   = '{cmd, inst, spawn, blk, mesh};
        d.typed = typed;
        d.res   = '{st, fi, fb, fm};
        directed_rows.push_back(d);
    endtask

    // Offer one request, hold it until accepted, then record what it should return
    task automatic send_request(request_t r, logic typed, result_t typed_res);
        int      gap;
        result_t predicted;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= r.cmd;
        instance_number <= r.inst;
        spawn_instance  <= r.spawn;
        block_number    <= r.blk;
        mesh_number     <= r.mesh;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_to_rows(r);
        awaited_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n, int ins_pct, int rem_pct, bit sq, bit rq, bit with_hold);
        sender_quiet   = sq;
        receiver_quiet = rq;
        for (int i = 0; i < n; i++)
        begin
            if (with_hold && i == 20)
                long_hold_pending = 1'b1;
            send_request(random_request(ins_pct, rem_pct), 1'b0, '0);
        end
        pause_until_drained();
    endtask

    task automatic report_mismatch(string field, longint exp_v, longint act_v);
        error_count++;
        if (error_count <= 50)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
    endtask

    // Receiver: random stall per result, plus one long hold on request
    initial
    begin
        int stall;
        int held;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                stall             = LONG_HOLD;
                long_hold_pending = 1'b0;
            end
            else
                stall = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                held = 0;
                while (held < stall)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 50)
                    $display("%0t: unexpected result: expected none, actual status %0h",
                             $time, status);
            end
            else
            begin
                oldest_result = awaited_results.pop_front();
                if (status !== oldest_result.status)
                    report_mismatch("status", oldest_result.status, status);
                if (found_instance !== oldest_result.f_inst)
                    report_mismatch("found_instance", oldest_result.f_inst, found_instance);
                if (found_block !== oldest_result.f_blk)
                    report_mismatch("found_block", oldest_result.f_blk, found_block);
                if (found_mesh !== oldest_result.f_mesh)
                    report_mismatch("found_mesh", oldest_result.f_mesh, found_mesh);
            end
        end
    end

    initial
    begin
        request_t r;
        rst_n             = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        row_total         = 0;
        sender_quiet      = 1'b0;
        receiver_quiet    = 1'b0;
        long_hold_pending = 1'b0;
        in_valid        <= 1'b0;
        command         <= mkit_pkg::CMD_INSERT;
        instance_number <= '0;
        spawn_instance  <= '0;
        block_number    <= '0;
        mesh_number     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, extremes, partial keys, renumber, remove with wrap, spare codes
        add_row(mkit_pkg::CMD_LOOKUP_KEY, 16'h0, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_MISS, 0, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_INS, 16'h0, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_MISS, 0, 0, 0);
        add_row(mkit_pkg::CMD_REMOVE, 16'h0, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_MISS, 0, 0, 0);
        add_row(mkit_pkg::CMD_RENUMBER, 16'h0, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_INSERT, 16'h0, 16'hFFFF, 16'hFFFF, 8'hFF, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_INSERT, 16'hFFFF, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_INSERT, 16'd5, 16'h1234, 16'd10, 8'd3, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_INSERT, 16'h0, 16'd1, 16'd20, 8'd3, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_KEY, 16'h0, 16'hFFFF, 16'hFFFF, 8'hFF, 1,
                mkit_pkg::STAT_OK, 16'h0, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_KEY, 16'h0, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_OK, 16'hFFFF, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_INS, 16'hFFFF, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_OK, 0, 16'h0, 8'h0);
        add_row(mkit_pkg::CMD_LOOKUP_INS, 16'h0, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_OK, 0, 16'hFFFF, 8'hFF);
        add_row(mkit_pkg::CMD_LOOKUP_KEY, 16'h0, 16'h1234, 16'd10, 8'd4, 1,
                mkit_pkg::STAT_MISS, 0, 0, 0);
        add_row(mkit_pkg::CMD_RENUMBER, 16'h0, 16'h0, 16'd10, 8'd3, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_KEY, 16'h0, 16'd1, 16'd19, 8'd3, 0,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_REMOVE, 16'd5, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_KEY, 16'h0, 16'd1, 16'd19, 8'd3, 0,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_REMOVE, 16'd7, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_MISS, 0, 0, 0);
        add_row(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1,
                mkit_pkg::STAT_MISS, 0, 0, 0);
        add_row(CMD_SPARE_HI, 16'h0, 16'h0, 16'h0, 8'h0, 1,
                mkit_pkg::STAT_MISS, 0, 0, 0);
        add_row(mkit_pkg::CMD_RENUMBER, 16'h0, 16'h0, 16'h0, 8'hFF, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_INS, 16'h0, 16'h0, 16'h0, 8'h0, 0,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_RENUMBER, 16'h0, 16'h0, 16'hFFFF, 8'h0, 1,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_REMOVE, 16'h0, 16'h0, 16'h0, 8'h0, 0,
                mkit_pkg::STAT_OK, 0, 0, 0);
        add_row(mkit_pkg::CMD_LOOKUP_INS, 16'hFFFE, 16'h0, 16'h0, 8'h0, 0,
                mkit_pkg::STAT_OK, 0, 0, 0);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

        // Fill to capacity, then bounce off the full table
        while (row_total < mkit_pkg::CAPACITY)
        begin
            r     = '0;
            r.cmd = mkit_pkg::CMD_INSERT;
            {r.inst, r.spawn, r.blk, r.mesh} = 56'({$urandom, $urandom, $urandom});
            send_request(r, 1'b0, '0);
        end
        repeat (3)
        begin
            r.cmd = mkit_pkg::CMD_INSERT;
            send_request(r, 1'b1, '{mkit_pkg::STAT_FULL, 16'h0, 16'h0, 8'h0});
        end
        pause_until_drained();

        run_phase(300, 40, 20, 1'b0, 1'b0, 1'b0);
        run_phase(200, 70, 5, 1'b1, 1'b1, 1'b0);
        run_phase(250, 20, 20, 1'b0, 1'b1, 1'b1);
        run_phase(250, 5, 60, 1'b0, 1'b0, 1'b0);
        run_phase(250, 35, 25, 1'b0, 1'b0, 1'b0);
        run_phase(250, 45, 15, 1'b1, 1'b0, 1'b0);

        // Catch any stray result after the last one expected
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mkit_pkg.sv
rtl/mkit_cell.sv
rtl/mkit_resolve.sv
rtl/multi_key_instance_table_unit.sv
rtl/mkit_checker.sv
dv/multi_key_instance_table_unit_tb.sv
